>>> rtl/crf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the clipped rectangle fill block.
package crf_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int TILE_W      = 2;
    localparam int COORD_W     = 8;
    localparam int WIN_W       = 6;
    localparam int SIDE_W      = 6;
    localparam int COUNT_W     = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int TILES_PER_BYTE = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y      = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST = 6'd32;
    localparam logic [COORD_W-1:0] VIEW_X_RST      = 8'd16;
    localparam logic [COORD_W-1:0] VIEW_Y_RST      = 8'd16;

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Clipped range on one axis, window relative
    typedef struct packed {
        logic [SIDE_W-1:0] start;
        logic [SIDE_W-1:0] count;
    } axis_clip_t;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CLIP   = 7'b0000100,
        ST_SETUP  = 7'b0001000,
        ST_RD     = 7'b0010000,
        ST_WR     = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

endpackage

>>> rtl/crf_ifs.sv
`timescale 1ns / 1ps
// Handshake channel interfaces: fill/read requests, results and register writes.
interface crf_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [crf_pkg::COORD_W-1:0]  rect_x;
    logic [crf_pkg::COORD_W-1:0]  rect_y;
    logic [crf_pkg::COORD_W-1:0]  rect_width;
    logic [crf_pkg::COORD_W-1:0]  rect_height;
    logic [crf_pkg::TILE_W-1:0]   tile_type;
    logic [crf_pkg::ADDR_W-1:0]   read_address;

    modport source (output valid, kind, rect_x, rect_y, rect_width, rect_height,
                    tile_type, read_address, input ready);
    modport sink   (input valid, kind, rect_x, rect_y, rect_width, rect_height,
                    tile_type, read_address, output ready);
endinterface

interface crf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [crf_pkg::BYTE_W-1:0]   read_byte;
    logic [crf_pkg::COUNT_W-1:0]  tiles_written;

    modport source (output valid, read_byte, tiles_written, input ready);
    modport sink   (input valid, read_byte, tiles_written, output ready);
endinterface

interface crf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crf_pkg::CFG_IDX_W-1:0]  index;
    logic [crf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/crf_store.sv
`timescale 1ns / 1ps
// Tile store: 256 bytes, one write and one registered read port.
module crf_store
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [crf_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [crf_pkg::BYTE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [crf_pkg::ADDR_W-1:0]  rd_addr,
    output logic [crf_pkg::BYTE_W-1:0]  rd_data
);

    logic [crf_pkg::BYTE_W-1:0] mem [crf_pkg::STORE_DEPTH];
    logic [crf_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/crf_clip.sv
`timescale 1ns / 1ps
// Clip one axis of a rectangle to the window centred on the view coordinate.
module crf_clip
(
    input  logic [crf_pkg::COORD_W-1:0] view,
    input  logic [crf_pkg::SIDE_W-1:0]  side,
    input  logic [crf_pkg::COORD_W-1:0] base,
    input  logic [crf_pkg::COORD_W-1:0] len,
    output crf_pkg::axis_clip_t         clip
);

    logic signed [10:0] lo;
    logic signed [10:0] hi;
    logic signed [10:0] b_s;
    logic signed [10:0] e_s;
    logic signed [10:0] s;
    logic signed [10:0] e;
    logic signed [10:0] start_w;
    logic signed [10:0] count_w;
    logic signed [10:0] side_s;

    always_comb
    begin
        side_s  = $signed({5'b0, side});
        lo      = $signed({3'b0, view}) - $signed({6'b0, side[5:1]});
        hi      = $signed({3'b0, view}) + $signed({6'b0, side[5:1]});
        b_s     = $signed({3'b0, base});
        e_s     = $signed({3'b0, base}) + $signed({3'b0, len});
        s       = (b_s > lo) ? b_s : lo;
        e       = (e_s < hi) ? e_s : hi;
        start_w = s - lo;
        count_w = e - s;
        if (e <= s)
        begin
            start_w = '0;
            count_w = '0;
        end
        // Keep the range inside the window
        if (start_w > side_s)
        begin
            start_w = side_s;
        end
        if (count_w > side_s - start_w)
        begin
            count_w = side_s - start_w;
        end
        clip.start = start_w[crf_pkg::SIDE_W-1:0];
        clip.count = count_w[crf_pkg::SIDE_W-1:0];
    end

endmodule

>>> rtl/clipped_rect_fill_2bpp.sv
`timescale 1ns / 1ps
// Read item: the store read is registered, then ST_FINISH loads the result register once the
//   output is free. Fill item: ST_CLIP, ST_SETUP, then one read-modify-write of the store per
//   byte of each row (ST_RD reads, ST_WR writes), then ST_FINISH loads the result register.
// One item at a time; a new request is taken while a result waits to be taken.
// Reset: the state, configuration and result valid registers return to their defaults and a
//   clear pass zeroes the store, during which no request is accepted.
module clipped_rect_fill_2bpp
#(
    parameter int MAX_WINDOW = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    crf_req_if.sink    req,
    crf_rsp_if.source  rsp,
    crf_cfg_if.sink    cfg
);

    crf_pkg::state_t state_reg, state_next;

    logic [crf_pkg::WIN_W-1:0]   window_size_reg;
    logic [crf_pkg::COORD_W-1:0] view_x_reg;
    logic [crf_pkg::COORD_W-1:0] view_y_reg;

    logic [crf_pkg::ADDR_W-1:0]  clr_cnt_reg;

    logic                         kind_reg;
    logic [crf_pkg::COORD_W-1:0]  rect_x_reg;
    logic [crf_pkg::COORD_W-1:0]  rect_y_reg;
    logic [crf_pkg::COORD_W-1:0]  rect_w_reg;
    logic [crf_pkg::COORD_W-1:0]  rect_h_reg;
    logic [crf_pkg::TILE_W-1:0]   tile_type_reg;

    crf_pkg::axis_clip_t          x_clip, y_clip, x_clip_reg, y_clip_reg;

    logic [crf_pkg::SIDE_W-1:0]   x_end_reg;
    logic [crf_pkg::SIDE_W-3:0]   bx_reg;
    logic [crf_pkg::SIDE_W-1:0]   rows_left_reg;
    logic [crf_pkg::ADDR_W-1:0]   row_base_reg;
    logic [crf_pkg::COUNT_W-1:0]  tiles_reg;

    logic                         out_valid_reg;
    logic [crf_pkg::BYTE_W-1:0]   out_byte_reg;
    logic [crf_pkg::COUNT_W-1:0]  out_tiles_reg;

    logic [crf_pkg::WIN_W:0]      win_clamped;
    logic [crf_pkg::SIDE_W-1:0]   side;
    logic [crf_pkg::SIDE_W-3:0]   quarter;
    logic                         req_fire;
    logic                         out_free;
    logic [crf_pkg::SIDE_W-1:0]   x_end;
    logic [crf_pkg::SIDE_W-1:0]   x_last;
    logic [11:0]                  area;
    logic [9:0]                   base_prod;
    logic [crf_pkg::ADDR_W-1:0]   cur_addr;
    logic [crf_pkg::BYTE_W-1:0]   bit_mask;
    logic [crf_pkg::BYTE_W-1:0]   fill_byte;
    logic [crf_pkg::SIDE_W-1:0]   tile_pos;

    logic                         wr_en;
    logic [crf_pkg::ADDR_W-1:0]   wr_addr;
    logic [crf_pkg::BYTE_W-1:0]   wr_data;
    logic                         rd_en;
    logic [crf_pkg::ADDR_W-1:0]   rd_addr;
    logic [crf_pkg::BYTE_W-1:0]   rd_data;

    // Effective side: clamp to the largest window, round down to a multiple of four
    always_comb
    begin
        win_clamped = ({1'b0, window_size_reg} > (crf_pkg::WIN_W+1)'(MAX_WINDOW))
                    ? (crf_pkg::WIN_W+1)'(MAX_WINDOW) : {1'b0, window_size_reg};
        side        = {win_clamped[crf_pkg::SIDE_W-1:2], 2'b00};
        quarter     = side[crf_pkg::SIDE_W-1:2];
    end

    crf_clip u_clip_x
    (
        .view (view_x_reg),
        .side (side),
        .base (rect_x_reg),
        .len  (rect_w_reg),
        .clip (x_clip)
    );

    crf_clip u_clip_y
    (
        .view (view_y_reg),
        .side (side),
        .base (rect_y_reg),
        .len  (rect_h_reg),
        .clip (y_clip)
    );

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == crf_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free = !out_valid_reg || rsp.ready;

    assign x_end     = x_clip_reg.start + x_clip_reg.count - 6'd1;
    assign x_last    = x_end_reg;
    assign area      = x_clip_reg.count * y_clip_reg.count;
    assign base_prod = y_clip_reg.start * quarter;
    assign cur_addr  = row_base_reg + crf_pkg::ADDR_W'(bx_reg);
    assign fill_byte = {crf_pkg::TILES_PER_BYTE{tile_type_reg}};

    // Select the tiles of the current byte that fall inside the clipped columns
    always_comb
    begin
        bit_mask = '0;
        tile_pos = '0;
        for (int t = 0; t < crf_pkg::TILES_PER_BYTE; t++)
        begin
            tile_pos = {bx_reg, 2'(t)};
            if (tile_pos >= x_clip_reg.start && tile_pos <= x_last)
            begin
                bit_mask[2*t +: 2] = 2'b11;
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = (rd_data & ~bit_mask) | (fill_byte & bit_mask);
        rd_en   = 1'b0;
        rd_addr = cur_addr;
        case (state_reg)
            crf_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            crf_pkg::ST_IDLE:
            begin
                rd_en   = req_fire && (req.kind == crf_pkg::KIND_READ);
                rd_addr = req.read_address;
            end
            crf_pkg::ST_RD:
            begin
                rd_en = 1'b1;
            end
            crf_pkg::ST_WR:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    crf_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crf_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == crf_pkg::ADDR_W'(crf_pkg::STORE_DEPTH - 1))
                begin
                    state_next = crf_pkg::ST_IDLE;
                end
            end
            crf_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.kind == crf_pkg::KIND_READ)
                               ? crf_pkg::ST_FINISH : crf_pkg::ST_CLIP;
                end
            end
            crf_pkg::ST_CLIP:
            begin
                state_next = crf_pkg::ST_SETUP;
            end
            crf_pkg::ST_SETUP:
            begin
                if (x_clip_reg.count == '0 || y_clip_reg.count == '0)
                begin
                    state_next = crf_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = crf_pkg::ST_RD;
                end
            end
            crf_pkg::ST_RD:
            begin
                state_next = crf_pkg::ST_WR;
            end
            crf_pkg::ST_WR:
            begin
                if (bx_reg == x_last[crf_pkg::SIDE_W-1:2] && rows_left_reg == 6'd1)
                begin
                    state_next = crf_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = crf_pkg::ST_RD;
                end
            end
            crf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = crf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= crf_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            window_size_reg <= crf_pkg::WINDOW_SIZE_RST;
            view_x_reg      <= crf_pkg::VIEW_X_RST;
            view_y_reg      <= crf_pkg::VIEW_Y_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == crf_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 8'd1;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    crf_pkg::CFG_WINDOW_SIZE: window_size_reg <= cfg.data[crf_pkg::WIN_W-1:0];
                    crf_pkg::CFG_VIEW_X:      view_x_reg      <= cfg.data;
                    crf_pkg::CFG_VIEW_Y:      view_y_reg      <= cfg.data;
                    default:                  view_y_reg      <= view_y_reg;
                endcase
            end
            if (state_reg == crf_pkg::ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg      <= req.kind;
            rect_x_reg    <= req.rect_x;
            rect_y_reg    <= req.rect_y;
            rect_w_reg    <= req.rect_width;
            rect_h_reg    <= req.rect_height;
            tile_type_reg <= req.tile_type;
        end
        case (state_reg)
            crf_pkg::ST_CLIP:
            begin
                x_clip_reg <= x_clip;
                y_clip_reg <= y_clip;
            end
            crf_pkg::ST_SETUP:
            begin
                x_end_reg     <= x_end;
                bx_reg        <= x_clip_reg.start[crf_pkg::SIDE_W-1:2];
                rows_left_reg <= y_clip_reg.count;
                row_base_reg  <= base_prod[crf_pkg::ADDR_W-1:0];
                tiles_reg     <= area[crf_pkg::COUNT_W-1:0];
            end
            crf_pkg::ST_WR:
            begin
                // Advance along the row, then wrap to the next row
                if (bx_reg == x_last[crf_pkg::SIDE_W-1:2])
                begin
                    bx_reg        <= x_clip_reg.start[crf_pkg::SIDE_W-1:2];
                    rows_left_reg <= rows_left_reg - 6'd1;
                    row_base_reg  <= row_base_reg + crf_pkg::ADDR_W'(quarter);
                end
                else
                begin
                    bx_reg <= bx_reg + 4'd1;
                end
            end
            crf_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_byte_reg  <= (kind_reg == crf_pkg::KIND_READ) ? rd_data : '0;
                    out_tiles_reg <= (kind_reg == crf_pkg::KIND_READ) ? '0 : tiles_reg;
                end
            end
            default:
            begin
                tiles_reg <= tiles_reg;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_byte     = out_byte_reg;
    assign rsp.tiles_written = out_tiles_reg;

endmodule

>>> rtl/crf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the clipped rectangle fill block, bound to the top level.
module crf_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  logic [crf_pkg::BYTE_W-1:0]   rsp_read_byte,
    input  logic [crf_pkg::COUNT_W-1:0]  rsp_tiles_written
);

    // No result during reset
    a_no_rsp_in_reset: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
                                    && $stable(rsp_tiles_written))
        else $error("stalled result changed");

    // A result carries either a byte or a tile count, never both
    a_rsp_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_read_byte == '0 || rsp_tiles_written == '0))
        else $error("result carries both byte and count");

    // One item at a time: busy right after a request transaction
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind clipped_rect_fill_2bpp crf_checker u_crf_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_read_byte     (rsp.read_byte),
    .rsp_tiles_written (rsp.tiles_written)
);
